@@ rtl/btc_pkg.sv @@
// Shared types, constants and helpers for the bit matrix transitive closure block.
package btc_pkg;

	// Field widths fixed by the interface
	localparam int CLS_W = 6;
	localparam int ROW_W = 64;
	localparam int CC_W  = 7;

	localparam int NUM_CLASSES_DEF = 64;
	localparam logic [CC_W-1:0] CC_RESET = 7'd64;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_CLOSE = 2'd1,
		MODE_ROW   = 2'd2,
		MODE_COL   = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [CLS_W-1:0]  first_class;
		logic [CLS_W-1:0]  second_class;
	} cmd_t;

	typedef struct packed {
		logic [ROW_W-1:0]  class_set;
		logic              index_error;
	} res_t;

	// Sequencer to matrix memory
	typedef struct packed {
		logic              we;
		logic [CLS_W-1:0]  waddr;
		logic [ROW_W-1:0]  wdata;
		logic [CLS_W-1:0]  raddr;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_WR,
		ST_ROW_RD,
		ST_COL_RUN,
		ST_CL_PIV,
		ST_CL_RUN,
		ST_RESP
	} st_t;

	// Ones in the bits below n
	function automatic logic [ROW_W-1:0] count_mask(input logic [CC_W-1:0] n);
		logic [ROW_W-1:0] m;
		if (n >= CC_W'(ROW_W)) begin
			m = '1;
		end else begin
			m = (ROW_W'(1) << n) - ROW_W'(1);
		end
		return m;
	endfunction

endpackage

@@ rtl/btc_ram.sv @@
// Reachability matrix memory: one write and one registered read port, identity after reset.
module btc_ram #(
	parameter int NUM_CLASSES = btc_pkg::NUM_CLASSES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  btc_pkg::mem_req_t        req,
	output logic [btc_pkg::ROW_W-1:0] rdata
);

	localparam int IW = $clog2(NUM_CLASSES);

	logic [btc_pkg::ROW_W-1:0] mem [NUM_CLASSES];
	logic [NUM_CLASSES-1:0]    vld_q;
	logic [IW-1:0]             wa;
	logic [IW-1:0]             ra;
	logic [btc_pkg::ROW_W-1:0] rd_s1;
	logic [btc_pkg::ROW_W-1:0] wd_s1;
	logic [IW-1:0]             ra_s1;
	logic                      fwd_s1;
	logic                      rv_s1;

	assign wa = req.waddr[IW-1:0];
	assign ra = req.raddr[IW-1:0];

	// Array write and registered read; same-cycle write is forwarded
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[wa] <= req.wdata;
		end
		rd_s1  <= mem[ra];
		wd_s1  <= req.wdata;
		ra_s1  <= ra;
		fwd_s1 <= req.we && (req.waddr == req.raddr);
	end

	// Row written flags; an unwritten row reads as its identity row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv_s1 <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[wa] <= 1'b1;
			end
			rv_s1 <= vld_q[ra];
		end
	end

	assign rdata = fwd_s1 ? wd_s1 :
	               rv_s1  ? rd_s1 : (btc_pkg::ROW_W'(1) << ra_s1);

endmodule

@@ rtl/btc_seq.sv @@
// Command sequencer: edge add, row and column queries, Warshall sweep over the matrix memory.
module btc_seq #(
	parameter int NUM_CLASSES = btc_pkg::NUM_CLASSES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  btc_pkg::cmd_t             cmd,
	input  logic [btc_pkg::CC_W-1:0]  class_count,
	output logic                      busy,
	output logic                      done,
	output btc_pkg::res_t             res,
	output btc_pkg::mem_req_t         mreq,
	input  logic [btc_pkg::ROW_W-1:0] rdata
);

	localparam int IW = $clog2(NUM_CLASSES);
	localparam int CW = $clog2(NUM_CLASSES + 1);

	btc_pkg::st_t st_q, st_d;

	logic [CW-1:0]                n;
	logic                         a_err;
	logic                         b_err;
	logic                         cmd_err;
	logic                         issue;
	logic [CW-1:0]                i_q;
	logic [CW-1:0]                k_q;
	logic                         iss_q;
	logic                         vld_s1;
	logic [IW-1:0]                i_s1;
	logic [IW-1:0]                k_s1;
	logic                         last_s1;
	logic                         klast_s1;
	logic                         hit_nxt;
	logic [btc_pkg::CLS_W-1:0]    a_q;
	logic [btc_pkg::CLS_W-1:0]    b_q;
	logic [btc_pkg::ROW_W-1:0]    set_q;
	logic                         err_q;
	logic [btc_pkg::ROW_W-1:0]    pivot_q;
	logic [btc_pkg::ROW_W-1:0]    pvt_nxt_q;
	logic [btc_pkg::ROW_W-1:0]    new_row;

	// Active count and index checks
	assign n = (class_count > btc_pkg::CC_W'(NUM_CLASSES)) ? CW'(NUM_CLASSES)
	                                                     : CW'(class_count);
	assign a_err = {1'b0, cmd.first_class}  >= btc_pkg::CC_W'(n);
	assign b_err = {1'b0, cmd.second_class} >= btc_pkg::CC_W'(n);

	always_comb begin
		case (cmd.mode)
			btc_pkg::MODE_ADD:   cmd_err = a_err || b_err;
			btc_pkg::MODE_CLOSE: cmd_err = 1'b0;
			default:             cmd_err = a_err;
		endcase
	end

	// Position of the beat returning from memory
	assign last_s1  = (CW'(i_s1) == n - CW'(1));
	assign klast_s1 = (CW'(k_s1) == n - CW'(1));
	assign hit_nxt  = (CW'(i_s1) == CW'(k_s1) + CW'(1));
	assign new_row  = rdata[k_s1] ? (rdata | pivot_q) : rdata;

	assign busy = (st_q != btc_pkg::ST_IDLE);
	assign res  = '{class_set: set_q, index_error: err_q};

	// Next state, memory requests, result strobe
	always_comb begin
		st_d  = st_q;
		mreq  = '0;
		issue = 1'b0;
		done  = 1'b0;
		unique case (st_q)
			btc_pkg::ST_IDLE: begin
				if (start) begin
					unique case (cmd.mode)
						btc_pkg::MODE_ADD: begin
							if (cmd_err) begin
								st_d = btc_pkg::ST_RESP;
							end else begin
								mreq.raddr = cmd.first_class;
								st_d       = btc_pkg::ST_ADD_WR;
							end
						end
						btc_pkg::MODE_CLOSE: begin
							// pivot read of row 0
							st_d = (n == '0) ? btc_pkg::ST_RESP : btc_pkg::ST_CL_PIV;
						end
						btc_pkg::MODE_ROW: begin
							if (cmd_err) begin
								st_d = btc_pkg::ST_RESP;
							end else begin
								mreq.raddr = cmd.first_class;
								st_d       = btc_pkg::ST_ROW_RD;
							end
						end
						btc_pkg::MODE_COL: begin
							if (cmd_err) begin
								st_d = btc_pkg::ST_RESP;
							end else begin
								issue = 1'b1;
								st_d  = btc_pkg::ST_COL_RUN;
							end
						end
					endcase
				end
			end
			btc_pkg::ST_ADD_WR: begin
				mreq.we    = 1'b1;
				mreq.waddr = a_q;
				mreq.wdata = rdata | (btc_pkg::ROW_W'(1) << b_q);
				st_d       = btc_pkg::ST_RESP;
			end
			btc_pkg::ST_ROW_RD: begin
				st_d = btc_pkg::ST_RESP;
			end
			btc_pkg::ST_COL_RUN: begin
				if (i_q < n) begin
					issue      = 1'b1;
					mreq.raddr = btc_pkg::CLS_W'(i_q);
				end
				if (vld_s1 && last_s1) begin
					st_d = btc_pkg::ST_RESP;
				end
			end
			btc_pkg::ST_CL_PIV: begin
				issue      = iss_q;
				mreq.raddr = btc_pkg::CLS_W'(i_q);
				st_d       = btc_pkg::ST_CL_RUN;
			end
			btc_pkg::ST_CL_RUN: begin
				issue      = iss_q;
				mreq.raddr = btc_pkg::CLS_W'(i_q);
				if (vld_s1) begin
					mreq.we    = rdata[k_s1];
					mreq.waddr = btc_pkg::CLS_W'(i_s1);
					mreq.wdata = new_row;
					if (last_s1 && klast_s1) begin
						st_d = btc_pkg::ST_RESP;
					end
				end
			end
			btc_pkg::ST_RESP: begin
				done = 1'b1;
				st_d = btc_pkg::ST_IDLE;
			end
			default: st_d = btc_pkg::ST_IDLE;
		endcase
	end

	// State and sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= btc_pkg::ST_IDLE;
			vld_s1 <= 1'b0;
			iss_q  <= 1'b0;
			i_q    <= '0;
			k_q    <= '0;
		end else begin
			st_q   <= st_d;
			vld_s1 <= issue && (st_q != btc_pkg::ST_IDLE || cmd.mode == btc_pkg::MODE_COL);
			if (st_q == btc_pkg::ST_IDLE) begin
				i_q   <= (cmd.mode == btc_pkg::MODE_COL) ? CW'(1) : '0;
				k_q   <= '0;
				iss_q <= 1'b1;
			end else if (issue) begin
				if (st_q == btc_pkg::ST_COL_RUN) begin
					i_q <= i_q + CW'(1);
				end else if (i_q == n - CW'(1)) begin
					// end of a row sweep: next pivot
					i_q <= '0;
					if (k_q == n - CW'(1)) begin
						iss_q <= 1'b0;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end else begin
					i_q <= i_q + CW'(1);
				end
			end
		end
	end

	// Result and pivot registers
	always_ff @(posedge clk) begin
		if (issue) begin
			i_s1 <= (st_q == btc_pkg::ST_IDLE) ? '0 : i_q[IW-1:0];
			k_s1 <= k_q[IW-1:0];
		end
		unique case (st_q)
			btc_pkg::ST_IDLE: begin
				if (start) begin
					a_q   <= cmd.first_class;
					b_q   <= cmd.second_class;
					set_q <= '0;
					err_q <= cmd_err;
				end
			end
			btc_pkg::ST_ROW_RD: begin
				set_q <= rdata & btc_pkg::count_mask(btc_pkg::CC_W'(n));
			end
			btc_pkg::ST_COL_RUN: begin
				if (vld_s1) begin
					set_q[i_s1] <= rdata[a_q];
				end
			end
			btc_pkg::ST_CL_PIV: begin
				pivot_q <= rdata;
			end
			btc_pkg::ST_CL_RUN: begin
				if (vld_s1) begin
					// keep the final value of row k+1 for the next sweep
					if (hit_nxt) begin
						pvt_nxt_q <= new_row;
					end
					if (last_s1) begin
						pivot_q <= hit_nxt ? new_row : pvt_nxt_q;
					end
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted command did not raise busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy held after result beat");
	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.we |-> busy) else $error("matrix write while idle");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.index_error |-> res.class_set == '0)
		else $error("error result carries a class set");
`endif

endmodule

@@ rtl/bit_matrix_transitive_closure.sv @@
// Top level: class count register, command sequencer and reachability matrix memory.
//
// Keeps a reachability bit matrix (row i = classes that class i reaches), identity after reset,
// in a single memory with one read and one write port; every command is serialized through that
// read port. A command is taken when start is high and busy is low; its one result is shown on
// res with done high for exactly one cycle and cannot be stalled. With n the smaller of
// class_count and NUM_CLASSES: an edge add reads one row and writes it back with one bit set, a
// row read returns one row masked to the first n classes, a column read does one memory read per
// row, a closure does one row read-modify-write per pivot and row, and any index error or a
// closure with n of zero goes straight to the result. busy drops in the cycle after done.
// class_count is written over the cfg channel, which is ready only while the block is idle.
module bit_matrix_transitive_closure #(
	parameter int NUM_CLASSES = btc_pkg::NUM_CLASSES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  btc_pkg::cmd_t            cmd,
	output logic                     busy,
	output logic                     done,
	output btc_pkg::res_t            res,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [btc_pkg::CC_W-1:0] cfg_data
);

	logic [btc_pkg::CC_W-1:0]  cc_q;
	btc_pkg::mem_req_t         mreq;
	logic [btc_pkg::ROW_W-1:0] rdata;

	assign cfg_ready = !busy;

	// Class count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= btc_pkg::CC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cc_q <= cfg_data;
		end
	end

	btc_seq #(
		.NUM_CLASSES (NUM_CLASSES)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.class_count (cc_q),
		.busy        (busy),
		.done        (done),
		.res         (res),
		.mreq        (mreq),
		.rdata       (rdata)
	);

	btc_ram #(
		.NUM_CLASSES (NUM_CLASSES)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (rdata)
	);

endmodule
